/* src/tccs_pkg.sv */
// Shared types and constants for the text console core.
// Used by the channel interfaces, the controller, the datapath and the top level.
package tccs_pkg;

	localparam int CHAR_W  = 8;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int CELL_W  = 16;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 2'd2;

	localparam logic [COL_W-1:0]  RESET_COLUMNS = 7'd80;
	localparam logic [ROW_W-1:0]  RESET_ROWS    = 5'd25;
	localparam logic [CHAR_W-1:0] RESET_ATTR    = 8'h07;
	localparam logic [CHAR_W-1:0] FILL_ATTR     = 8'h00;

	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

	typedef enum logic [1:0] {
		WALK_INIT  = 2'd0,
		WALK_CLEAR = 2'd1,
		WALK_COPY  = 2'd2,
		WALK_FILL  = 2'd3
	} walk_mode_t;

	typedef enum logic [2:0] {
		CS_INIT   = 3'd0,
		CS_IDLE   = 3'd1,
		CS_EXEC   = 3'd2,
		CS_CLEAR  = 3'd3,
		CS_COPY   = 3'd4,
		CS_DRAIN  = 3'd5,
		CS_FILL   = 3'd6,
		CS_FINISH = 3'd7
	} ctrl_state_t;

	typedef struct packed {
		logic       accept;
		logic       exec;
		logic       walk_start;
		walk_mode_t start_mode;
		logic       walk_step;
		walk_mode_t mode;
		logic       load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic scroll;
		logic multi_row;
		logic walk_last;
	} dp_status_t;

endpackage

/* src/tccs_if.sv */
// Request and response channel interfaces of the text console core.
// Depends on tccs_pkg for the field widths.
interface tccs_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   opcode;
	logic [tccs_pkg::CHAR_W-1:0]  char_code;
	logic [tccs_pkg::COL_W-1:0]   read_col;
	logic [tccs_pkg::ROW_W-1:0]   read_row;

	modport source(output valid, opcode, char_code, read_col, read_row, input ready);
	modport sink(input valid, opcode, char_code, read_col, read_row, output ready);
endinterface

interface tccs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tccs_pkg::CHAR_W-1:0]  cell_char;
	logic [tccs_pkg::CHAR_W-1:0]  cell_attr;
	logic [tccs_pkg::COL_W-1:0]   cursor_col;
	logic [tccs_pkg::ROW_W-1:0]   cursor_row;

	modport source(output valid, cell_char, cell_attr, cursor_col, cursor_row, input ready);
	modport sink(input valid, cell_char, cell_attr, cursor_col, cursor_row, output ready);
endinterface

/* src/tccs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tccs_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/tccs_ctrl.sv */
// Controller state machine of the text console core: handshakes, item sequencing
// and the screen walks. Depends on tccs_pkg.
module tccs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tccs_pkg::dp_status_t st,
	output tccs_pkg::ctrl_cmd_t  cmd
);

	tccs_pkg::ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tccs_pkg::CS_INIT: begin
				if (st.walk_last) state_d = tccs_pkg::CS_IDLE;
			end
			tccs_pkg::CS_IDLE: begin
				if (in_valid) state_d = tccs_pkg::CS_EXEC;
			end
			tccs_pkg::CS_EXEC: begin
				if (st.is_clear) begin
					state_d = tccs_pkg::CS_CLEAR;
				end else if (st.scroll) begin
					state_d = st.multi_row ? tccs_pkg::CS_COPY : tccs_pkg::CS_FILL;
				end else begin
					state_d = tccs_pkg::CS_FINISH;
				end
			end
			tccs_pkg::CS_CLEAR: begin
				if (st.walk_last) state_d = tccs_pkg::CS_FINISH;
			end
			tccs_pkg::CS_COPY: begin
				if (st.walk_last) state_d = tccs_pkg::CS_DRAIN;
			end
			tccs_pkg::CS_DRAIN: begin
				state_d = tccs_pkg::CS_FILL;
			end
			tccs_pkg::CS_FILL: begin
				if (st.walk_last) state_d = tccs_pkg::CS_FINISH;
			end
			tccs_pkg::CS_FINISH: begin
				if (out_free) begin
					state_d = in_valid ? tccs_pkg::CS_EXEC : tccs_pkg::CS_IDLE;
				end
			end
			default: state_d = tccs_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.start_mode = tccs_pkg::WALK_CLEAR;
		cmd.mode       = tccs_pkg::WALK_CLEAR;
		case (state_q)
			tccs_pkg::CS_INIT: begin
				cmd.walk_step = 1'b1;
				cmd.mode      = tccs_pkg::WALK_INIT;
			end
			tccs_pkg::CS_IDLE: begin
				in_ready = 1'b1;
			end
			tccs_pkg::CS_EXEC: begin
				cmd.exec = 1'b1;
				if (st.is_clear) begin
					cmd.walk_start = 1'b1;
					cmd.start_mode = tccs_pkg::WALK_CLEAR;
				end else if (st.scroll) begin
					cmd.walk_start = 1'b1;
					cmd.start_mode = st.multi_row ? tccs_pkg::WALK_COPY : tccs_pkg::WALK_FILL;
				end
			end
			tccs_pkg::CS_CLEAR: begin
				cmd.walk_step = 1'b1;
				cmd.mode      = tccs_pkg::WALK_CLEAR;
			end
			tccs_pkg::CS_COPY: begin
				cmd.walk_step = 1'b1;
				cmd.mode      = tccs_pkg::WALK_COPY;
			end
			tccs_pkg::CS_DRAIN: begin
				cmd.walk_start = 1'b1;
				cmd.start_mode = tccs_pkg::WALK_FILL;
			end
			tccs_pkg::CS_FILL: begin
				cmd.walk_step = 1'b1;
				cmd.mode      = tccs_pkg::WALK_FILL;
			end
			tccs_pkg::CS_FINISH: begin
				cmd.load_out = out_free;
				in_ready     = out_free;
			end
			default: ;
		endcase
		cmd.accept = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tccs_pkg::CS_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over one that was not taken");

	a_no_request_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::CS_INIT) |-> !in_ready)
		else $error("request taken before the screen was initialized");

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::CS_EXEC) |=> (state_q != tccs_pkg::CS_EXEC))
		else $error("request executed twice");

	a_copy_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tccs_pkg::CS_COPY && st.walk_last) |=> (state_q == tccs_pkg::CS_DRAIN))
		else $error("scroll copy did not drain its last write");

	a_exec_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == tccs_pkg::CS_EXEC))
		else $error("accepted request was not executed");

endmodule

/* src/tccs_dp.sv */
// Datapath of the text console core: configuration, cursor, cell memory,
// screen walker and result register. Depends on tccs_pkg and tccs_ram.
module tccs_dp #(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tccs_pkg::CFG_W-1:0]        cfg_data,
	input  tccs_pkg::ctrl_cmd_t               cmd,
	output tccs_pkg::dp_status_t              st,
	input  logic [1:0]                        opcode,
	input  logic [tccs_pkg::CHAR_W-1:0]       char_code,
	input  logic [tccs_pkg::COL_W-1:0]        read_col,
	input  logic [tccs_pkg::ROW_W-1:0]        read_row,
	output logic [tccs_pkg::CHAR_W-1:0]       cell_char,
	output logic [tccs_pkg::CHAR_W-1:0]       cell_attr,
	output logic [tccs_pkg::COL_W-1:0]        cursor_col,
	output logic [tccs_pkg::ROW_W-1:0]        cursor_row
);

	localparam int AX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AY_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ADDR_W = AX_W + AY_W;
	localparam int DEPTH  = MAX_ROWS * (2 ** AX_W);

	localparam logic [tccs_pkg::COL_W:0]   MAX_COLS_C = (tccs_pkg::COL_W + 1)'(MAX_COLS);
	localparam logic [tccs_pkg::ROW_W:0]   MAX_ROWS_C = (tccs_pkg::ROW_W + 1)'(MAX_ROWS);
	localparam logic [tccs_pkg::COL_W-1:0] COL_LAST   = tccs_pkg::COL_W'(MAX_COLS - 1);
	localparam logic [tccs_pkg::ROW_W-1:0] ROW_LAST   = tccs_pkg::ROW_W'(MAX_ROWS - 1);

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [tccs_pkg::COL_W-1:0] x,
			input logic [tccs_pkg::ROW_W-1:0] y);
		return {y[AY_W-1:0], x[AX_W-1:0]};
	endfunction

	// Configuration registers.
	logic [tccs_pkg::COL_W-1:0]  columns_q;
	logic [tccs_pkg::ROW_W-1:0]  rows_q;
	logic [tccs_pkg::CHAR_W-1:0] color_q;

	// Accepted request.
	tccs_pkg::op_t               op_q;
	logic [tccs_pkg::CHAR_W-1:0] ch_q;
	logic                        rok_q;

	logic [tccs_pkg::COL_W-1:0]  cx_q, wx_q;
	logic [tccs_pkg::ROW_W-1:0]  cy_q, wy_q;
	logic [tccs_pkg::CELL_W-1:0] cell_q;
	logic [tccs_pkg::CHAR_W-1:0] cell_char_q, cell_attr_q;
	logic [tccs_pkg::COL_W-1:0]  cursor_col_q;
	logic [tccs_pkg::ROW_W-1:0]  cursor_row_q;

	logic                        copy_pend_s1;
	logic [ADDR_W-1:0]           copy_dst_s1;

	logic [tccs_pkg::COL_W-1:0]  ncl, cx_c, nx, put_x, xl;
	logic [tccs_pkg::ROW_W-1:0]  nrl, cy_c, ny, yl, start_y;
	logic [tccs_pkg::CHAR_W-1:0] put_ch;
	logic                        put_we, wrap_row, scroll, in_ok;

	logic                        we;
	logic [ADDR_W-1:0]           waddr, raddr;
	logic [tccs_pkg::CELL_W-1:0] wdata, rd_data;

	// Last active column and row, with out-of-range sizes clamped.
	always_comb begin
		if (columns_q == '0) begin
			ncl = '0;
		end else if ({1'b0, columns_q} > MAX_COLS_C) begin
			ncl = COL_LAST;
		end else begin
			ncl = columns_q - 1'b1;
		end
		if (rows_q == '0) begin
			nrl = '0;
		end else if ({1'b0, rows_q} > MAX_ROWS_C) begin
			nrl = ROW_LAST;
		end else begin
			nrl = rows_q - 1'b1;
		end
	end

	always_comb begin
		cx_c     = (cx_q > ncl) ? ncl : cx_q;
		cy_c     = (cy_q > nrl) ? nrl : cy_q;
		nx       = cx_q;
		ny       = cy_q;
		put_we   = 1'b0;
		put_x    = cx_c;
		put_ch   = ch_q;
		wrap_row = 1'b0;
		scroll   = 1'b0;
		case (op_q)
			tccs_pkg::OP_PUT: begin
				nx = cx_c;
				ny = cy_c;
				case (ch_q)
					tccs_pkg::CH_NEWLINE: begin
						nx       = '0;
						wrap_row = 1'b1;
					end
					tccs_pkg::CH_RETURN: begin
						nx = '0;
					end
					tccs_pkg::CH_BACKSPACE: begin
						nx     = (cx_c != '0) ? cx_c - 1'b1 : '0;
						put_we = 1'b1;
						put_x  = nx;
						put_ch = tccs_pkg::CH_BACKSPACE;
					end
					default: begin
						put_we = 1'b1;
						if (cx_c == ncl) begin
							nx       = '0;
							wrap_row = 1'b1;
						end else begin
							nx = cx_c + 1'b1;
						end
					end
				endcase
				// Running past the last row keeps the cursor there and scrolls.
				if (wrap_row) begin
					if (cy_c == nrl) begin
						scroll = 1'b1;
					end else begin
						ny = cy_c + 1'b1;
					end
				end
			end
			tccs_pkg::OP_CLEAR: begin
				nx = '0;
				ny = '0;
			end
			default: ;
		endcase
	end

	// Screen walker limits; the power-up pass covers all MAX_COLS by MAX_ROWS cells.
	always_comb begin
		xl = (cmd.mode == tccs_pkg::WALK_INIT) ? COL_LAST : ncl;
		yl = (cmd.mode == tccs_pkg::WALK_INIT) ? ROW_LAST : nrl;
		case (cmd.start_mode)
			tccs_pkg::WALK_COPY: start_y = 5'd1;
			tccs_pkg::WALK_FILL: start_y = nrl;
			default:             start_y = '0;
		endcase
	end

	assign st.is_clear  = (op_q == tccs_pkg::OP_CLEAR);
	assign st.scroll    = scroll;
	assign st.multi_row = (nrl != '0);
	assign st.walk_last = (wx_q == xl) && (wy_q == yl);

	assign in_ok = (read_col <= ncl) && (read_row <= nrl);

	always_comb begin
		we    = 1'b0;
		waddr = cell_addr(wx_q, wy_q);
		wdata = {tccs_pkg::RESET_ATTR, tccs_pkg::CH_SPACE};
		if (copy_pend_s1) begin
			we    = 1'b1;
			waddr = copy_dst_s1;
			wdata = rd_data;
		end else if (cmd.exec && put_we) begin
			we    = 1'b1;
			waddr = cell_addr(put_x, cy_c);
			wdata = {color_q, put_ch};
		end else if (cmd.walk_step) begin
			case (cmd.mode)
				tccs_pkg::WALK_INIT: begin
					we    = 1'b1;
					wdata = {tccs_pkg::RESET_ATTR, tccs_pkg::CH_SPACE};
				end
				tccs_pkg::WALK_CLEAR: begin
					we    = 1'b1;
					wdata = {color_q, tccs_pkg::CH_SPACE};
				end
				tccs_pkg::WALK_FILL: begin
					we    = 1'b1;
					wdata = {tccs_pkg::FILL_ATTR, tccs_pkg::CH_SPACE};
				end
				default: ;
			endcase
		end
	end

	// A read request fetches its cell in the cycle it is accepted.
	always_comb begin
		if (cmd.accept) begin
			raddr = in_ok ? cell_addr(read_col, read_row) : '0;
		end else begin
			raddr = cell_addr(wx_q, wy_q);
		end
	end

	tccs_ram #(
		.WIDTH (tccs_pkg::CELL_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_cells (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q    <= tccs_pkg::RESET_COLUMNS;
			rows_q       <= tccs_pkg::RESET_ROWS;
			color_q      <= tccs_pkg::RESET_ATTR;
			cx_q         <= '0;
			cy_q         <= '0;
			wx_q         <= '0;
			wy_q         <= '0;
			copy_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tccs_pkg::REG_COLUMNS:    columns_q <= cfg_data[tccs_pkg::COL_W-1:0];
					tccs_pkg::REG_ROWS:       rows_q    <= cfg_data[tccs_pkg::ROW_W-1:0];
					tccs_pkg::REG_TEXT_COLOR: color_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.exec) begin
				cx_q <= nx;
				cy_q <= ny;
			end
			if (cmd.walk_start) begin
				wx_q <= '0;
				wy_q <= start_y;
			end else if (cmd.walk_step) begin
				if (wx_q == xl) begin
					wx_q <= '0;
					wy_q <= wy_q + 1'b1;
				end else begin
					wx_q <= wx_q + 1'b1;
				end
			end
			copy_pend_s1 <= cmd.walk_step && (cmd.mode == tccs_pkg::WALK_COPY);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= tccs_pkg::op_t'(opcode);
			ch_q  <= char_code;
			rok_q <= in_ok;
		end
		copy_dst_s1 <= cell_addr(wx_q, wy_q - 1'b1);
		if (cmd.exec) begin
			cell_q <= (op_q == tccs_pkg::OP_READ && rok_q) ? rd_data : '0;
		end
		if (cmd.load_out) begin
			cell_char_q  <= cell_q[tccs_pkg::CHAR_W-1:0];
			cell_attr_q  <= cell_q[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
			cursor_col_q <= cx_q;
			cursor_row_q <= cy_q;
		end
	end

	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;

	a_copy_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		copy_pend_s1 |-> !(cmd.exec ||
			(cmd.walk_step && cmd.mode != tccs_pkg::WALK_COPY)))
		else $error("scroll copy write collides with another write");

endmodule

/* src/text_console_cursor_scroll_core.sv */
// Top level of the text console core: channel interfaces, controller and datapath.
// Depends on tccs_pkg, tccs_if, tccs_ctrl and tccs_dp.
//
//   Port     Dir   Kind           Carries
//   req      in    valid/ready    opcode, char_code, read_col, read_row
//   rsp      out   valid/ready    cell_char, cell_attr, cursor_col, cursor_row
//   cfg_*    in    write strobe   cfg_index selects columns, rows or text_color
//
// Put, read and no-op requests run back to back while results are taken, each
// through an accept step (the read port of the cell memory fetches then) and an
// execute step. A clear adds a walk over all rows*columns cells; a scroll adds a
// copy of rows 1 up to the last one row up, a drain of the last copy write and a
// fill of the last row, or only the fill on a one-row screen, one cell per cycle
// through the single cell memory. After reset a pass writes all MAX_ROWS*MAX_COLS
// cells before the first request is taken. A result that is not taken holds the
// next request in its last cycle, and no further request is accepted until then.
module text_console_cursor_scroll_core #(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tccs_pkg::CFG_W-1:0]     cfg_data,
	tccs_req_if.sink                       req,
	tccs_rsp_if.source                     rsp
);

	tccs_pkg::ctrl_cmd_t  cmd;
	tccs_pkg::dp_status_t st;

	tccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.st       (st),
		.cmd      (cmd)
	);

	tccs_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.opcode    (req.opcode),
		.char_code (req.char_code),
		.read_col  (req.read_col),
		.read_row  (req.read_row),
		.cell_char (rsp.cell_char),
		.cell_attr (rsp.cell_attr),
		.cursor_col(rsp.cursor_col),
		.cursor_row(rsp.cursor_row)
	);

endmodule

/* test/text_console_cursor_scroll_core_checker.sv */
`timescale 1ns / 100ps
// Checker for the text console core: follows the configuration port and both
// channels, predicts every response and compares it field by field.
// Depends on tccs_pkg and the channel interfaces of tccs_if.
module text_console_cursor_scroll_core_checker #(
	parameter int MAX_COLS = 80,
	parameter int MAX_ROWS = 25
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tccs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tccs_pkg::CFG_W-1:0]     cfg_data,
	tccs_req_if                            req,
	tccs_rsp_if                            rsp,
	output int                             errors,
	output int                             pending
);
	import tccs_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
	} console_status_t;

	logic [CELL_W-1:0] screen [MAX_ROWS][MAX_COLS];
	int unsigned       cur_x;
	int unsigned       cur_y;
	logic [COL_W-1:0]  columns;
	logic [ROW_W-1:0]  rows;
	logic [CHAR_W-1:0] text_color;
	console_status_t   expected_status [$];

	function automatic int unsigned used_cols();
		if (columns == 0) return 1;
		if (columns > MAX_COLS) return MAX_COLS;
		return 32'(columns);
	endfunction

	function automatic int unsigned used_rows();
		if (rows == 0) return 1;
		if (rows > MAX_ROWS) return MAX_ROWS;
		return 32'(rows);
	endfunction

	function automatic void write_cell(int unsigned x, int unsigned y,
			logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
		if (x < MAX_COLS && y < MAX_ROWS) screen[y][x] = {attr, ch};
	endfunction

	function automatic void fill_area(logic [CHAR_W-1:0] attr, int unsigned nc,
			int unsigned nr);
		int unsigned x, y;
		for (y = 0; y < nr; y++)
			for (x = 0; x < nc; x++)
				write_cell(x, y, CH_SPACE, attr);
	endfunction

	// Moves the active rows up by one once the cursor has run past the last row.
	function automatic void scroll_up(int unsigned nc, int unsigned nr);
		int unsigned x, y;
		if (cur_y < nr) return;
		cur_y = nr - 1;
		for (y = 1; y < nr; y++)
			for (x = 0; x < nc; x++)
				screen[y - 1][x] = screen[y][x];
		for (x = 0; x < nc; x++)
			write_cell(x, nr - 1, CH_SPACE, FILL_ATTR);
	endfunction

	function automatic void put_char(logic [CHAR_W-1:0] c);
		int unsigned nc, nr;
		nc = used_cols();
		nr = used_rows();
		// The screen may have shrunk under the cursor since the last write.
		if (cur_x >= nc) cur_x = nc - 1;
		if (cur_y >= nr) cur_y = nr - 1;
		case (c)
			CH_NEWLINE: begin
				cur_y++;
				cur_x = 0;
				scroll_up(nc, nr);
			end
			CH_RETURN: begin
				cur_x = 0;
			end
			CH_BACKSPACE: begin
				if (cur_x > 0) cur_x--;
				write_cell(cur_x, cur_y, CH_BACKSPACE, text_color);
			end
			default: begin
				write_cell(cur_x, cur_y, c, text_color);
				cur_x++;
				if (cur_x >= nc) begin
					cur_x = 0;
					cur_y++;
					scroll_up(nc, nr);
				end
			end
		endcase
	endfunction

	function automatic console_status_t predict_status(op_t op, logic [CHAR_W-1:0] ch,
			logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
		console_status_t s;
		logic [CELL_W-1:0] entry;
		s = '0;
		case (op)
			OP_PUT: begin
				put_char(ch);
			end
			OP_CLEAR: begin
				fill_area(text_color, used_cols(), used_rows());
				cur_x = 0;
				cur_y = 0;
			end
			OP_READ: begin
				if (rc < used_cols() && rr < used_rows()) begin
					entry = screen[rr][rc];
					s.cell_char = entry[CHAR_W-1:0];
					s.cell_attr = entry[CELL_W-1:CHAR_W];
				end
			end
			default: begin
			end
		endcase
		s.cursor_col = cur_x[COL_W-1:0];
		s.cursor_row = cur_y[ROW_W-1:0];
		return s;
	endfunction

	function automatic void reset_console();
		fill_area(RESET_ATTR, MAX_COLS, MAX_ROWS);
		cur_x = 0;
		cur_y = 0;
		columns = RESET_COLUMNS;
		rows = RESET_ROWS;
		text_color = RESET_ATTR;
		expected_status.delete();
		errors = 0;
		pending = 0;
	endfunction

	function automatic void check_response();
		console_status_t got, want;
		got = {rsp.cell_char, rsp.cell_attr, rsp.cursor_col, rsp.cursor_row};
		if (expected_status.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: response with no request waiting: %s %h %h %0d %0d",
					$time, "char attr col row", got.cell_char, got.cell_attr,
					got.cursor_col, got.cursor_row);
			return;
		end
		want = expected_status.pop_front();
		if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
				got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row) begin
			errors++;
			if (errors <= 10)
				$display("%0t: expected char %h attr %h col %0d row %0d, %s %h %h %0d %0d",
					$time, want.cell_char, want.cell_attr, want.cursor_col,
					want.cursor_row, "got char attr col row", got.cell_char,
					got.cell_attr, got.cursor_col, got.cursor_row);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_console();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COLUMNS:    columns = cfg_data[COL_W-1:0];
					REG_ROWS:       rows = cfg_data[ROW_W-1:0];
					REG_TEXT_COLOR: text_color = cfg_data;
					default: begin
					end
				endcase
			end
			// Responses are taken first, so a stray one cannot pair with a request
			// that is accepted at the same edge.
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) check_response();
			if (req.valid === 1'b1 && req.ready === 1'b1)
				expected_status.push_back(predict_status(op_t'(req.opcode), req.char_code,
					req.read_col, req.read_row));
			pending = expected_status.size();
		end
	end

endmodule

/* test/text_console_cursor_scroll_core_tb.sv */
`timescale 1ns / 100ps
// Top of the text console core testbench: clock, reset, register writes and
// request stimulus with random idling on both channels, and the verdict.
// Depends on tccs_pkg, tccs_if, the core and text_console_cursor_scroll_core_checker.
module text_console_cursor_scroll_core_tb;
	import tccs_pkg::*;

	localparam int MAX_COLS     = 80;
	localparam int MAX_ROWS     = 25;
	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT  = 8000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 100;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int          errors;
	int          pending;
	int          cycles;
	bit          quiet;
	bit          hold_off;
	int unsigned used_cols = MAX_COLS;
	int unsigned used_rows = MAX_ROWS;

	tccs_req_if req();
	tccs_rsp_if rsp();

	text_console_cursor_scroll_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	text_console_cursor_scroll_core_checker #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Response side: random stalls, plus one long hold-off when asked for.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_off <= 1'b0;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic int unsigned clip_size(int unsigned value, int unsigned limit);
		if (value == 0) return 1;
		if (value > limit) return limit;
		return value;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance, with
	// valid left high so that a following request goes out without a gap.
	task automatic send_request(input op_t op, input logic [CHAR_W-1:0] ch,
			input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.char_code <= ch;
		req.read_col <= rc;
		req.read_row <= rr;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_responses();
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rws,
			input logic [CFG_W-1:0] color);
		req.valid <= 1'b0;
		wait_responses();
		write_register(REG_COLUMNS, cols);
		write_register(REG_ROWS, rws);
		write_register(REG_TEXT_COLOR, color);
		cfg_we <= 1'b0;
		used_cols = clip_size(32'(cols[COL_W-1:0]), MAX_COLS);
		used_rows = clip_size(32'(rws[ROW_W-1:0]), MAX_ROWS);
	endtask

	task automatic send_random_item(input bit big);
		int unsigned pick;
		logic [COL_W-1:0] rc;
		logic [ROW_W-1:0] rr;
		pick = $urandom_range(0, 99);
		rc = COL_W'($urandom_range(0, 127));
		rr = ROW_W'($urandom_range(0, 31));
		if (pick < 45)
			send_request(OP_PUT, CHAR_W'($urandom_range(8'h20, 8'h7E)), rc, rr);
		else if (pick < (big ? 47 : 53))
			send_request(OP_PUT, CH_NEWLINE, rc, rr);
		else if (pick < 57)
			send_request(OP_PUT, CH_RETURN, rc, rr);
		else if (pick < 62)
			send_request(OP_PUT, CH_BACKSPACE, rc, rr);
		else if (pick < 70)
			send_request(OP_PUT, CHAR_W'($urandom_range(0, 255)), rc, rr);
		else if (pick < 72)
			send_request(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), rc, rr);
		else if (pick < 75)
			send_request(OP_NONE, CHAR_W'($urandom_range(0, 255)), rc, rr);
		else if (pick < 94)
			send_request(OP_READ, CHAR_W'($urandom_range(0, 255)),
				COL_W'($urandom_range(0, used_cols - 1)),
				ROW_W'($urandom_range(0, used_rows - 1)));
		else
			send_request(OP_READ, CHAR_W'($urandom_range(0, 255)), rc, rr);
	endtask

	initial begin
		int unsigned phase;
		int unsigned sent;
		int unsigned n_items;
		int unsigned i;
		logic [CFG_W-1:0] cols, rws, color;
		bit big;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data = '0;
		req.valid = 1'b0;
		req.opcode = OP_NONE;
		req.char_code = '0;
		req.read_col = '0;
		req.read_row = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset size: corners, outside reads and control codes.
		send_request(OP_READ, 8'h00, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'd79, 5'd24);
		send_request(OP_READ, 8'h00, 7'd80, 5'd0);
		send_request(OP_READ, 8'h00, 7'd127, 5'd31);
		send_request(OP_PUT, 8'h41, 7'd0, 5'd0);
		send_request(OP_PUT, 8'h00, 7'd0, 5'd0);
		send_request(OP_PUT, 8'hFF, 7'd0, 5'd0);
		send_request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);
		send_request(OP_PUT, CH_RETURN, 7'd0, 5'd0);
		send_request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0);
		send_request(OP_PUT, CH_NEWLINE, 7'd0, 5'd0);
		send_request(OP_NONE, 8'hFF, 7'd127, 5'd31);
		send_request(OP_READ, 8'h00, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'd1, 5'd0);
		send_request(OP_CLEAR, 8'h00, 7'd0, 5'd0);

		// A tiny screen makes wrapping and scrolling happen within a few requests.
		configure(8'd3, 8'd2, 8'hA5);
		for (i = 0; i < 7; i++)
			send_request(OP_PUT, CHAR_W'(8'h61 + i), 7'd0, 5'd0);
		send_request(OP_PUT, CH_NEWLINE, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'd0, 5'd0);
		send_request(OP_READ, 8'h00, 7'd2, 5'd1);

		phase = 0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			color = CFG_W'($urandom_range(0, 255));
			case (phase)
				0: begin
					cols = 8'd1;
					rws = 8'd1;
					color = 8'h00;
				end
				1: begin
					// Upper bits beyond the register widths are dropped, leaving zero.
					cols = 8'h80;
					rws = 8'hE0;
					color = 8'hFF;
				end
				2: begin
					cols = 8'd127;
					rws = 8'd31;
				end
				3: begin
					cols = 8'd80;
					rws = 8'd25;
				end
				default: begin
					if (phase % 6 == 0) begin
						cols = CFG_W'($urandom_range(40, 127));
						rws = CFG_W'($urandom_range(10, 31));
					end else begin
						cols = CFG_W'($urandom_range(1, 12));
						rws = CFG_W'($urandom_range(1, 6));
					end
				end
			endcase
			configure(cols, rws, color);
			big = used_cols * used_rows > 200;
			n_items = big ? 15 : 40;
			if (sent >= RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
			if (phase == 5) hold_off <= 1'b1;
			if ($urandom_range(0, 9) < 6)
				send_request(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
					COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
			for (i = 0; i < n_items; i++)
				send_random_item(big);
			sent += n_items;
			phase++;
		end

		req.valid <= 1'b0;
		wait_responses();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
src/tccs_pkg.sv
src/tccs_if.sv
src/tccs_ram.sv
src/tccs_ctrl.sv
src/tccs_dp.sv
src/text_console_cursor_scroll_core.sv
test/text_console_cursor_scroll_core_checker.sv
test/text_console_cursor_scroll_core_tb.sv
